[src/wsma_pkg.sv]
// Shared constants, command codes and sequencer states for the wheel speed averager.
package wsma_pkg;

    localparam int DEFAULT_WINDOW     = 8;
    localparam int DEFAULT_COUNT_BITS = 16;

    localparam int TIME_W     = 32;
    localparam int RATE_W     = 32;
    localparam int RADIUS_W   = 16;
    localparam int RK_W       = 26;
    localparam int DT_SHIFT   = 6;
    localparam int DIV_W      = TIME_W + DT_SHIFT;
    localparam int DIV_STEPS  = RATE_W;
    localparam int SPEED_FRAC = 16;

    localparam logic [RATE_W-1:0]   PI_HALF_Q30  = 32'd1686629713;
    localparam logic [9:0]          SPEED_SCALE  = 10'd1000;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd3277;

    typedef enum logic [1:0] {
        CMD_LEFT   = 2'd0,
        CMD_RIGHT  = 2'd1,
        CMD_UPDATE = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_RATE,
        ST_RATE_PREP,
        ST_DIV_RATE,
        ST_RING_SUB,
        ST_RING_ADD,
        ST_AVG_PREP,
        ST_DIV_AVG,
        ST_SPEED_PREP,
        ST_MUL_SPEED,
        ST_EMIT
    } state_t;

endpackage

[src/wsma_ram.sv]
// Generic single write port RAM with one registered read port.
module wsma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/wheel_speed_moving_average_core.sv]
// Wheel encoder pulse counter with serial rate divider and moving average of angular rate.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------------
//  input    | in_valid / in_stall     | cmd, time_us
//  output   | out_valid / out_stall   | angle_rate, linear_speed, zero_interval
//  config   | cfg_wr_en               | cfg_wr_data (wheel radius, Q0.16)
//
// Pulse commands, ignored commands and the first update are taken while idle without raising
// in_stall. A later update holds in_stall high after its transfer until its result is
// registered: two bit-serial shift-add multiplies and two bit-serial restoring divides
// through one shared unit each, plus six further steps.
// rst_n clears counts, timestamp, ring valid bits, ring sum and index; the ring reads as zero.
// in_stall stays high until the update result sits in the output register; a stalled
// output holds the sequencer in its last step only when a second result is ready.
module wheel_speed_moving_average_core
    import wsma_pkg::*;
#(
    parameter int WINDOW     = DEFAULT_WINDOW,
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic [TIME_W-1:0]   time_us,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [RATE_W-1:0]   angle_rate,
    output logic [RATE_W-1:0]   linear_speed,
    output logic                zero_interval,
    input  logic                cfg_wr_en,
    input  logic [RADIUS_W-1:0] cfg_wr_data
);

    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = RATE_W + $clog2(WINDOW);
    localparam int MB_W   = (COUNT_BITS > RK_W) ? COUNT_BITS : RK_W;
    localparam int PW     = RATE_W + MB_W;
    localparam int STEP_W = $clog2((MB_W > DIV_STEPS) ? MB_W : DIV_STEPS);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW - 1);
    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MB_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

    state_t state_reg, state_next;

    logic [STEP_W-1:0]     step_reg, step_next;
    logic [COUNT_BITS-1:0] left_reg, left_next;
    logic [COUNT_BITS-1:0] right_reg, right_next;
    logic [TIME_W-1:0]     last_time_reg, last_time_next;
    logic                  time_seen_reg, time_seen_next;
    logic [RADIUS_W-1:0]   radius_reg, radius_next;
    logic [WINDOW-1:0]     valid_reg, valid_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  out_valid_reg, out_valid_next;

    logic [PW-1:0]         acc_reg, acc_next;
    logic [RATE_W-1:0]     mul_a_reg, mul_a_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [RATE_W-1:0]     q_reg, q_next;
    logic [DIV_W-1:0]      divisor_reg, divisor_next;
    logic [TIME_W-1:0]     dt_reg, dt_next;
    logic [RATE_W-1:0]     sample_reg, sample_next;
    logic                  sat_reg, sat_next;
    logic                  zero_reg, zero_next;
    logic [RATE_W-1:0]     angle_reg, angle_next;
    logic [RATE_W-1:0]     speed_reg, speed_next;
    logic                  zero_out_reg, zero_out_next;

    logic                  accept_in;
    logic                  update_go;
    logic                  out_free;
    logic                  mul_last;
    logic                  div_last;
    logic [COUNT_BITS:0]   pulse_sum;
    logic [RATE_W:0]       mul_sum;
    logic [PW-1:0]         acc_step;
    logic [DIV_W+1:0]      div_trial;
    logic [DIV_W-1:0]      rem_step;
    logic [RATE_W-1:0]     q_step;
    logic [RK_W-1:0]       radius_scaled;
    logic                  rate_sat;
    logic                  speed_sat;
    logic [RATE_W-1:0]     old_sample;
    logic                  ram_rd_en;
    logic                  ram_wr_en;
    logic [RATE_W-1:0]     ram_rd_data;

    // arithmetic steps
    assign accept_in = in_valid && !in_stall;
    assign update_go = accept_in && (cmd == CMD_UPDATE) && time_seen_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign mul_last  = (step_reg == MUL_LAST);
    assign div_last  = (step_reg == DIV_LAST);
    assign pulse_sum = {1'b0, left_reg} + {1'b0, right_reg};

    assign mul_sum  = {1'b0, acc_reg[PW-1:MB_W]} + (acc_reg[0] ? {1'b0, mul_a_reg} : '0);
    assign acc_step = {mul_sum, acc_reg[MB_W-1:1]};

    assign div_trial = {1'b0, rem_reg, q_reg[RATE_W-1]} - {2'b00, divisor_reg};
    assign rem_step  = div_trial[DIV_W+1] ? {rem_reg[DIV_W-2:0], q_reg[RATE_W-1]}
                                          : div_trial[DIV_W-1:0];
    assign q_step    = {q_reg[RATE_W-2:0], !div_trial[DIV_W+1]};

    assign radius_scaled = RK_W'(radius_reg) * RK_W'(SPEED_SCALE);
    assign rate_sat      = (acc_reg >> RATE_W) >= PW'({dt_reg, DT_SHIFT'(0)});
    assign speed_sat     = (acc_reg >> (SPEED_FRAC + RATE_W)) != '0;
    assign old_sample    = valid_reg[idx_reg] ? ram_rd_data : '0;

    wsma_ram #(
        .WIDTH (RATE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (sample_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (update_go)
                begin
                    state_next = ST_MUL_RATE;
                end
            end
            ST_MUL_RATE:
            begin
                if (mul_last)
                begin
                    state_next = ST_RATE_PREP;
                end
            end
            ST_RATE_PREP:  state_next = ST_DIV_RATE;
            ST_DIV_RATE:
            begin
                if (div_last)
                begin
                    state_next = ST_RING_SUB;
                end
            end
            ST_RING_SUB:   state_next = ST_RING_ADD;
            ST_RING_ADD:   state_next = ST_AVG_PREP;
            ST_AVG_PREP:   state_next = ST_DIV_AVG;
            ST_DIV_AVG:
            begin
                if (div_last)
                begin
                    state_next = ST_SPEED_PREP;
                end
            end
            ST_SPEED_PREP: state_next = ST_MUL_SPEED;
            ST_MUL_SPEED:
            begin
                if (mul_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = 1'b1;
        ram_rd_en = 1'b0;
        ram_wr_en = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                ram_rd_en = update_go;
            end
            ST_RING_ADD:
            begin
                ram_wr_en = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        step_next      = '0;
        left_next      = left_reg;
        right_next     = right_reg;
        last_time_next = last_time_reg;
        time_seen_next = time_seen_reg;
        radius_next    = cfg_wr_en ? cfg_wr_data : radius_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && out_stall;
        acc_next       = acc_reg;
        mul_a_next     = mul_a_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        divisor_next   = divisor_reg;
        dt_next        = dt_reg;
        sample_next    = sample_reg;
        sat_next       = sat_reg;
        zero_next      = zero_reg;
        angle_next     = angle_reg;
        speed_next     = speed_reg;
        zero_out_next  = zero_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    case (cmd)
                        CMD_LEFT:  left_next  = left_reg + 1'b1;
                        CMD_RIGHT: right_next = right_reg + 1'b1;
                        CMD_UPDATE:
                        begin
                            last_time_next = time_us;
                            time_seen_next = 1'b1;
                            if (time_seen_reg)
                            begin
                                dt_next    = time_us - last_time_reg;
                                zero_next  = (time_us == last_time_reg);
                                acc_next   = PW'(pulse_sum[COUNT_BITS:1]);
                                mul_a_next = PI_HALF_Q30;
                                left_next  = '0;
                                right_next = '0;
                            end
                        end
                        default:   left_next  = left_reg;
                    endcase
                end
            end
            ST_MUL_RATE, ST_MUL_SPEED:
            begin
                acc_next  = acc_step;
                step_next = mul_last ? '0 : step_reg + 1'b1;
            end
            ST_RATE_PREP:
            begin
                divisor_next = {dt_reg, DT_SHIFT'(0)};
                rem_next     = DIV_W'(acc_reg >> RATE_W);
                q_next       = acc_reg[RATE_W-1:0];
                sat_next     = rate_sat;
            end
            ST_DIV_RATE, ST_DIV_AVG:
            begin
                rem_next  = rem_step;
                q_next    = q_step;
                step_next = div_last ? '0 : step_reg + 1'b1;
            end
            ST_RING_SUB:
            begin
                sample_next = sat_reg ? '1 : q_reg;
                sum_next    = sum_reg - SUM_W'(old_sample);
            end
            ST_RING_ADD:
            begin
                sum_next            = sum_reg + SUM_W'(sample_reg);
                valid_next[idx_reg] = 1'b1;
                idx_next            = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            end
            ST_AVG_PREP:
            begin
                divisor_next = DIV_W'(WINDOW);
                rem_next     = DIV_W'(sum_reg >> RATE_W);
                q_next       = sum_reg[RATE_W-1:0];
            end
            ST_SPEED_PREP:
            begin
                mul_a_next = q_reg;
                acc_next   = PW'(radius_scaled);
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    angle_next     = q_reg;
                    speed_next     = speed_sat ? '1
                                               : acc_reg[SPEED_FRAC+RATE_W-1:SPEED_FRAC];
                    zero_out_next  = zero_reg;
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            last_time_reg <= '0;
            time_seen_reg <= 1'b0;
            radius_reg    <= RADIUS_RESET;
            valid_reg     <= '0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            last_time_reg <= last_time_next;
            time_seen_reg <= time_seen_next;
            radius_reg    <= radius_next;
            valid_reg     <= valid_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        mul_a_reg    <= mul_a_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        divisor_reg  <= divisor_next;
        dt_reg       <= dt_next;
        sample_reg   <= sample_next;
        sat_reg      <= sat_next;
        zero_reg     <= zero_next;
        angle_reg    <= angle_next;
        speed_reg    <= speed_next;
        zero_out_reg <= zero_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign angle_rate    = angle_reg;
    assign linear_speed  = speed_reg;
    assign zero_interval = zero_out_reg;

    // the ring sum never exceeds WINDOW full-scale samples
    assert property (@(posedge clk) disable iff (!rst_n)
        (sum_reg >> RATE_W) < SUM_W'(WINDOW))
        else $error("ring sum beyond window bound");

    // a zero time step always saturates the sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RING_SUB) && zero_reg |-> sat_reg)
        else $error("zero interval without saturation");

    // a new result appears only out of the final step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result raised outside final step");

    // each ring write advances the index
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RING_ADD) && (WINDOW > 1) |=> idx_reg != $past(idx_reg))
        else $error("ring index did not advance");

endmodule
